[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is high
`define HGF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked through reset
`define HGF_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/hgf_pkg.sv]
// ---------------------------------------------------------------------------
// hgf_pkg
// Constants, types and the arctangent step table of the geofence check.
// ---------------------------------------------------------------------------
package hgf_pkg;

  localparam int TRIG_ITERATIONS = 24;
  localparam int CORDIC_W        = 33;
  localparam int SQRT_STEPS      = 31;
  localparam int COS_LAT         = TRIG_ITERATIONS + 5;
  localparam int PIPE_DEPTH      = 1 + COS_LAT + 3 + SQRT_STEPS + TRIG_ITERATIONS + 2;

  typedef logic signed [CORDIC_W-1:0] cordic_t;

  localparam logic [29:0] DEG90        = 30'd94371840;
  localparam logic [29:0] DEG180       = 30'd188743680;
  localparam logic [29:0] DEG360       = 30'd377487360;
  localparam logic [26:0] RAD_SCALE    = 27'd74961321;
  localparam cordic_t     CORDIC_GAIN  = 33'sd652032874;
  localparam logic [23:0] TWO_R_METERS = 24'd12742000;
  localparam logic [24:0] MAX_DISTANCE = 25'd20015086;
  localparam logic [30:0] Q30_ONE      = 31'd1073741824;

  // configuration register indexes
  localparam logic [1:0] REG_REF_LAT = 2'd0;
  localparam logic [1:0] REG_REF_LON = 2'd1;
  localparam logic [1:0] REG_RADIUS  = 2'd2;

  localparam cordic_t ATAN_HEAD [10] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159, 33'sd67021687,
    33'sd33543516, 33'sd16775851, 33'sd8388437, 33'sd4194283, 33'sd2097149
  };

  // atan(2^-i) in Q30 radians
  function automatic cordic_t atan_step(int i);
    cordic_t r;
    if (i < 10) begin
      r = ATAN_HEAD[i];
    end else if (i <= 30) begin
      r = cordic_t'(33'sd1 <<< (30 - i));
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

[hdl/hgf_cordic.sv]
// ---------------------------------------------------------------------------
// hgf_cordic
// Unrolled CORDIC, one micro-rotation per register stage, rotation or
// vectoring mode.
// ---------------------------------------------------------------------------
module hgf_cordic (
  input  logic            clk,
  input  logic            en,
  input  logic            vec_mode,
  input  hgf_pkg::cordic_t x_in,
  input  hgf_pkg::cordic_t y_in,
  input  hgf_pkg::cordic_t z_in,
  output hgf_pkg::cordic_t x_out,
  output hgf_pkg::cordic_t z_out
);
  import hgf_pkg::*;

  cordic_t xr [TRIG_ITERATIONS];
  cordic_t yr [TRIG_ITERATIONS];
  cordic_t zr [TRIG_ITERATIONS];

  for (genvar gi = 0; gi < TRIG_ITERATIONS; gi++) begin : g_stage
    cordic_t xi, yi, zi, dx, dy;
    logic    up;

    if (gi == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = xr[gi-1];
      assign yi = yr[gi-1];
      assign zi = zr[gi-1];
    end

    assign dx = yi >>> gi;
    assign dy = xi >>> gi;
    // vectoring drives y to zero, rotation drives z to zero
    assign up = vec_mode ? !yi[CORDIC_W-1] : zi[CORDIC_W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (up) begin
          xr[gi] <= xi + dx;
          yr[gi] <= yi - dy;
          zr[gi] <= zi + atan_step(gi);
        end else begin
          xr[gi] <= xi - dx;
          yr[gi] <= yi + dy;
          zr[gi] <= zi - atan_step(gi);
        end
      end
    end
  end

  assign x_out = xr[TRIG_ITERATIONS-1];
  assign z_out = zr[TRIG_ITERATIONS-1];

endmodule

[hdl/hgf_cos.sv]
// ---------------------------------------------------------------------------
// hgf_cos
// Pipelined cosine of an angle in degrees * 2^20, Q30 result.
// ---------------------------------------------------------------------------
module hgf_cos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [29:0] angle,
  output logic signed [31:0] cos_q30
);
  import hgf_pkg::*;

  logic [29:0] a_abs;
  logic [28:0] a_mod;
  logic [27:0] a_half;
  logic [26:0] a_quad;
  logic        neg_c;
  logic [54:0] z_round;
  logic [TRIG_ITERATIONS-1:0] neg_dly;
  cordic_t     z0, x_cord, z_cord;
  logic signed [31:0] x_clamp;

  // stage registers
  logic [29:0] a_s1;
  logic [28:0] a_s2;
  logic [26:0] a_s3;
  logic        neg_s3;
  logic [53:0] prod_s4;
  logic        neg_s4;

  assign a_abs = angle[29] ? 30'(-angle) : 30'(angle);

  // |angle| < 2 * 360 deg, so one subtract reduces it
  assign a_mod  = (a_s1 >= DEG360) ? 29'(a_s1 - DEG360) : a_s1[28:0];
  assign a_half = ({1'b0, a_s2} > DEG180) ? 28'(DEG360 - {1'b0, a_s2}) : a_s2[27:0];
  assign neg_c  = ({2'b0, a_half} > DEG90);
  assign a_quad = neg_c ? 27'(DEG180 - {2'b0, a_half}) : a_half[26:0];

  always_ff @(posedge clk) begin
    if (en) begin
      a_s1    <= a_abs;
      a_s2    <= a_mod;
      a_s3    <= a_quad;
      neg_s3  <= neg_c;
      prod_s4 <= a_s3 * RAD_SCALE;
      neg_s4  <= neg_s3;
      neg_dly <= {neg_dly[TRIG_ITERATIONS-2:0], neg_s4};
    end
  end

  // degrees * 2^20 to Q30 radians, rounded
  assign z_round = {1'b0, prod_s4} + 55'(1 << 21);
  assign z0      = cordic_t'(z_round[54:22]);

  hgf_cordic u_cordic (
    .clk      (clk),
    .en       (en),
    .vec_mode (1'b0),
    .x_in     (CORDIC_GAIN),
    .y_in     ('0),
    .z_in     (z0),
    .x_out    (x_cord),
    .z_out    (z_cord)
  );

  always_comb begin
    if (x_cord[CORDIC_W-1]) begin
      x_clamp = '0;
    end else if (x_cord > cordic_t'(Q30_ONE)) begin
      x_clamp = 32'(Q30_ONE);
    end else begin
      x_clamp = x_cord[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q30 <= neg_dly[TRIG_ITERATIONS-1] ? -x_clamp : x_clamp;
    end
  end

endmodule

[hdl/haversine_geofence_check_top.sv]
// ---------------------------------------------------------------------------
// haversine_geofence_check_top
// Great-circle distance to a reference point with a geofence flag.
// ---------------------------------------------------------------------------
// Input words on s_t* carry one point (latitude, longitude in degrees * 2^20).
// Output words on m_t* carry the haversine distance in whole meters and a
// flag that is 1 when the point lies within radius_m (always 1 for radius 0).
// Reference point and radius are to be written on cfg_* while the stream is idle;
// the user is bound by this, and the block itself does not enforce it.
// Fully pipelined: one word accepted per cycle while the output is not
// stalled, PIPE_DEPTH = 90 register stages. The depth is set by the input
// register, the cosine pipeline (24 CORDIC stages + 5), the two square
// roots (31 stages, one result bit each), the vectoring CORDIC (24 stages)
// and the product/scaling stages.
//
// Reset clears all valid bits and the configuration registers.
// When m_tready is low with a valid output, the whole pipeline holds and
// s_tready drops; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module haversine_geofence_check_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_latitude[27:0], point_longitude[56:28], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // distance_m[24:0], in_radius[25], zero pad
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [28:0] cfg_data
);
  import hgf_pkg::*;

  logic en;
  logic [PIPE_DEPTH-1:0] vld;

  logic signed [27:0] ref_lat;
  logic signed [28:0] ref_lon;
  logic [24:0]        radius;

  logic signed [27:0] plat;
  logic signed [28:0] plon;

  logic signed [29:0] ang_dlat, ang_dlon, ang_plat, ang_rlat;
  logic signed [31:0] cos_dlat, cos_dlon, cos_plat, cos_rlat;

  logic signed [31:0] term1, omc, term1_d;
  logic signed [63:0] cprod, m2;
  logic signed [31:0] prod32, term2;
  logic signed [32:0] hsum;
  logic [30:0]        h;

  logic [61:0] rem_s [SQRT_STEPS];
  logic [61:0] root_s [SQRT_STEPS];
  logic [61:0] rem_c [SQRT_STEPS];
  logic [61:0] root_c [SQRT_STEPS];

  cordic_t     x_vec, z_vec;
  logic [30:0] z_pos;
  logic [54:0] dist_prod;
  logic [24:0] dist_raw, dist_sat;
  logic [24:0] dist_q;
  logic        in_radius_q;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PIPE_DEPTH-1];
  assign m_tdata  = {6'b0, in_radius_q, dist_q};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_lat <= '0;
      ref_lon <= '0;
      radius  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_REF_LAT: ref_lat <= cfg_data[27:0];
        REG_REF_LON: ref_lon <= cfg_data[28:0];
        REG_RADIUS:  radius  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plat <= s_tdata[27:0];
      plon <= s_tdata[56:28];
    end
  end

  assign ang_dlat = {{2{ref_lat[27]}}, ref_lat} - {{2{plat[27]}}, plat};
  assign ang_dlon = {ref_lon[28], ref_lon} - {plon[28], plon};
  assign ang_plat = {{2{plat[27]}}, plat};
  assign ang_rlat = {{2{ref_lat[27]}}, ref_lat};

  hgf_cos u_cos_dlat (.clk(clk), .en(en), .angle(ang_dlat), .cos_q30(cos_dlat));
  hgf_cos u_cos_dlon (.clk(clk), .en(en), .angle(ang_dlon), .cos_q30(cos_dlon));
  hgf_cos u_cos_plat (.clk(clk), .en(en), .angle(ang_plat), .cos_q30(cos_plat));
  hgf_cos u_cos_rlat (.clk(clk), .en(en), .angle(ang_rlat), .cos_q30(cos_rlat));

  // haversine sum: (1 - cos dLat)/2 + cos lat1 cos lat2 (1 - cos dLon)/2
  assign prod32 = 32'(cprod >>> 30);
  assign term2  = 32'(m2 >>> 30);
  assign hsum   = 33'(term1_d) + 33'(term2);

  always_ff @(posedge clk) begin
    if (en) begin
      term1   <= 32'((33'(Q30_ONE) - 33'(cos_dlat)) >>> 1);
      omc     <= 32'((33'(Q30_ONE) - 33'(cos_dlon)) >>> 1);
      cprod   <= cos_plat * cos_rlat;
      term1_d <= term1;
      m2      <= prod32 * omc;
      if (hsum[32]) begin
        h <= '0;
      end else if (hsum > 33'(Q30_ONE)) begin
        h <= Q30_ONE;
      end else begin
        h <= hsum[30:0];
      end
    end
  end

  // two bit-serial square roots, one root bit per stage
  for (genvar gj = 0; gj < SQRT_STEPS; gj++) begin : g_sqrt
    logic [61:0] bitv, rs_i, qs_i, rc_i, qc_i, trial_s, trial_c;

    assign bitv = 62'(1) << (2 * (SQRT_STEPS - 1 - gj));

    if (gj == 0) begin : g_first
      assign rs_i = {1'b0, h, 30'b0};
      assign rc_i = {1'b0, 31'(Q30_ONE - h), 30'b0};
      assign qs_i = '0;
      assign qc_i = '0;
    end else begin : g_next
      assign rs_i = rem_s[gj-1];
      assign rc_i = rem_c[gj-1];
      assign qs_i = root_s[gj-1];
      assign qc_i = root_c[gj-1];
    end

    assign trial_s = qs_i + bitv;
    assign trial_c = qc_i + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rs_i >= trial_s) begin
          rem_s[gj]  <= rs_i - trial_s;
          root_s[gj] <= (qs_i >> 1) + bitv;
        end else begin
          rem_s[gj]  <= rs_i;
          root_s[gj] <= qs_i >> 1;
        end
        if (rc_i >= trial_c) begin
          rem_c[gj]  <= rc_i - trial_c;
          root_c[gj] <= (qc_i >> 1) + bitv;
        end else begin
          rem_c[gj]  <= rc_i;
          root_c[gj] <= qc_i >> 1;
        end
      end
    end
  end

  // atan2(s, c) gives the half central angle
  hgf_cordic u_atan (
    .clk      (clk),
    .en       (en),
    .vec_mode (1'b1),
    .x_in     (cordic_t'({2'b0, root_c[SQRT_STEPS-1][30:0]})),
    .y_in     (cordic_t'({2'b0, root_s[SQRT_STEPS-1][30:0]})),
    .z_in     ('0),
    .x_out    (x_vec),
    .z_out    (z_vec)
  );

  assign z_pos    = z_vec[CORDIC_W-1] ? '0 : z_vec[30:0];
  assign dist_raw = dist_prod[54:30];
  assign dist_sat = (dist_raw > MAX_DISTANCE) ? MAX_DISTANCE : dist_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_prod   <= z_pos * TWO_R_METERS;
      dist_q      <= dist_sat;
      in_radius_q <= (radius == '0) || (dist_sat <= radius);
    end
  end

endmodule

[hdl/hgf_checker.sv]
// ---------------------------------------------------------------------------
// hgf_checker
// Port-level checks of the geofence block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hgf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import hgf_pkg::*;

  `HGF_ASSERT_NR(a_rst_clears, clk, rst |=> !m_tvalid, "output valid right after reset")
  `HGF_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
  `HGF_ASSERT(a_ready, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")
  `HGF_ASSERT(a_sat, clk, rst, m_tvalid |-> m_tdata[24:0] <= MAX_DISTANCE, "distance above half circumference")

endmodule

bind haversine_geofence_check_top hgf_checker u_hgf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stream test of the haversine geofence check: a directed table, then random
// points under several reference/radius settings and flow-control mixes,
// each output word checked against an in-bench fixed-point distance model.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hgf_pkg::*;

  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;
  localparam int     RAD_MAX = 20015087;
  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_CYCLES = 120;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [24:0] dist_m;
    logic        in_fence;
  } fence_result_t;

  // fixed rows carry a typed-in in_radius flag
  typedef struct {
    bit     fixed;
    longint lat;
    longint lon;
    bit     in_fence;
  } point_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // point_latitude[27:0], point_longitude[56:28], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // distance_m[24:0], in_radius[25], zero pad
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [28:0] cfg_data;

  haversine_geofence_check_top uut (.*);

  // predictor copy of the configuration
  logic [27:0] ref_lat_q;
  logic [28:0] ref_lon_q;
  logic [24:0] radius_q;

  fence_result_t result_q[$];
  point_row_t    pending_q[$];
  int            words_in, words_out, mismatches, cycles;
  int            idle_pct, stall_pct, hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- distance model ------------------------------------------------------
  function automatic longint arctan_q30(int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // cosine of degrees*2^20, Q30
  function automatic longint cosine_q30(longint v);
    longint unsigned a;
    longint x, y, z, dx, dy;
    bit flip;
    a = (v < 0) ? -v : v;
    flip = 1'b0;
    a = a % longint'(DEG360);
    if (a > longint'(DEG180)) a = longint'(DEG360) - a;
    if (a > longint'(DEG90)) begin
      flip = 1'b1;
      a = longint'(DEG180) - a;
    end
    z = longint'((a * longint'(RAD_SCALE) + (longint'(1) << 21)) >> 22);
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    if (x < 0) x = 0;
    if (x > (longint'(1) << 30)) x = longint'(1) << 30;
    return flip ? -x : x;
  endfunction

  function automatic fence_result_t fence_distance(logic [27:0] plat_b, logic [28:0] plon_b);
    longint one, plat, plon, rlat, rlon, cdlat, cdlon, t1, prod, t2, h, x, y, z, dx, dy, d;
    fence_result_t r;
    one  = longint'(1) << 30;
    plat = longint'($signed(plat_b));
    plon = longint'($signed(plon_b));
    rlat = longint'($signed(ref_lat_q));
    rlon = longint'($signed(ref_lon_q));
    cdlat = cosine_q30(rlat - plat);
    cdlon = cosine_q30(rlon - plon);
    t1   = (one - cdlat) >>> 1;
    prod = (cosine_q30(plat) * cosine_q30(rlat)) >>> 30;
    t2   = (prod * ((one - cdlon) >>> 1)) >>> 30;
    h = t1 + t2;
    if (h < 0) h = 0;
    if (h > one) h = one;
    y = root_floor(h << 30);
    x = root_floor((one - h) << 30);
    z = 0;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q30(i);
      end else begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end
    end
    if (z < 0) z = 0;
    d = (z * longint'(TWO_R_METERS)) >>> 30;
    if (d > longint'(MAX_DISTANCE)) d = longint'(MAX_DISTANCE);
    r.dist_m   = d[24:0];
    r.in_fence = (radius_q == 0) || (d <= longint'(radius_q));
    return r;
  endfunction

  // ---- monitor: inputs, config and outputs sampled at the rising edge ------
  always @(posedge clk) begin
    fence_result_t want, got;
    point_row_t row;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
    end
    if (rst) begin
      ref_lat_q <= '0;
      ref_lon_q <= '0;
      radius_q  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_REF_LAT: ref_lat_q <= cfg_data[27:0];
          REG_REF_LON: ref_lon_q <= cfg_data;
          REG_RADIUS:  radius_q  <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = fence_distance(s_tdata[27:0], s_tdata[56:28]);
        if (pending_q.size() != 0) begin
          row = pending_q.pop_front();
          if (row.fixed) begin
            want.in_fence = row.in_fence;
          end
        end
        result_q.insert(result_q.size(), want);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got.dist_m   = m_tdata[24:0];
        got.in_fence = m_tdata[25];
        words_out++;
        if (result_q.size() == 0) begin
          $display("%0t unexpected word: dist %0d in_radius %0b", $time, got.dist_m,
                   got.in_fence);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.dist_m !== want.dist_m) begin
            $display("%0t distance_m expected %0d actual %0d", $time, want.dist_m,
                     got.dist_m);
            mismatches++;
          end
          if (got.in_fence !== want.in_fence) begin
            $display("%0t in_radius expected %0b actual %0b", $time, want.in_fence,
                     got.in_fence);
            mismatches++;
          end
        end
      end
    end
  end

  // ---- receiver ------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // ---- sender helpers (called at a falling edge, return at one) ------------
  task automatic send_point(point_row_t row);
    int seen;
    seen = words_in;
    pending_q.insert(pending_q.size(), row);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, row.lon[28:0], row.lat[27:0]};
    do @(negedge clk); while (words_in == seen);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [28:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic longint rand_angle(longint lim, int width);
    if ($urandom_range(9) == 0)
      return longint'($urandom()) & ((longint'(1) << width) - 1);  // any bit pattern
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  // ---- stimulus ------------------------------------------------------------
  // reset configuration has radius 0, so every flag is 1
  point_row_t directed [14] = '{
    '{1'b1, 0, 0, 1'b1},                      // same point as reference
    '{1'b1, LAT_MAX, 0, 1'b1},                // north pole
    '{1'b1, -LAT_MAX, 0, 1'b1},               // south pole
    '{1'b1, 0, LON_MAX, 1'b1},                // antipode, saturates
    '{1'b1, 0, -LON_MAX, 1'b1},
    '{1'b1, LAT_MAX, LON_MAX, 1'b1},
    '{1'b1, -LAT_MAX, -LON_MAX, 1'b1},
    '{1'b1, 1, 1, 1'b1},                      // one step away
    '{1'b1, 125829120, 0, 1'b1},              // 120 deg: negative cosine product
    '{1'b1, 134217727, 268435455, 1'b1},      // largest bit patterns
    '{1'b1, -134217728, -268435456, 1'b1},    // smallest bit patterns
    '{1'b1, -1, -1, 1'b1},
    '{1'b1, 0, 377487360 - LON_MAX, 1'b1},
    '{1'b1, 47185920, -94371840, 1'b1}
  };

  initial begin
    point_row_t row;
    int phase_count;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_REF_LAT;
    cfg_data = '0;
    words_in = 0; words_out = 0; mismatches = 0; cycles = 0;
    idle_pct = 0; stall_pct = 0; hold_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: reference at origin, no radius limit
    foreach (directed[i]) send_point(directed[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;
             write_reg(REG_REF_LAT, 29'(LAT_MAX)); write_reg(REG_REF_LON, 29'(LON_MAX));
             write_reg(REG_RADIUS, 29'd1); end
        1: begin idle_pct = 81; stall_pct = 0;
             write_reg(REG_REF_LAT, 29'(-LAT_MAX)); write_reg(REG_REF_LON, 29'(-LON_MAX));
             write_reg(REG_RADIUS, 29'(RAD_MAX)); end
        2: begin idle_pct = 0;  stall_pct = 81;
             write_reg(REG_REF_LAT, 29'(rand_angle(LAT_MAX, 28)));
             write_reg(REG_REF_LON, 29'(rand_angle(LON_MAX, 29)));
             write_reg(REG_RADIUS, 29'($urandom_range(12000000, 2000000))); end
        3: begin idle_pct = 31; stall_pct = 31;
             write_reg(REG_REF_LAT, 29'($urandom()));
             write_reg(REG_REF_LON, 29'($urandom()));
             write_reg(REG_RADIUS, 29'h1FFFFFF);             // above range
             write_reg(REG_UNUSED, 29'($urandom())); end     // unused index, ignored
        default: begin idle_pct = 0; stall_pct = 0;
             write_reg(REG_REF_LAT, 29'(rand_angle(LAT_MAX, 28)));
             write_reg(REG_REF_LON, 29'(rand_angle(LON_MAX, 29)));
             write_reg(REG_RADIUS, 29'($urandom_range(9000000, 500))); end
      endcase
      phase_count = 0;
      while (phase_count < ITEMS_PER_PHASE) begin
        // long receiver hold-off while the sender keeps offering words
        if (ph == 4 && phase_count == 40) hold_cycles = 400;
        row.fixed = 1'b0;
        row.lat = rand_angle(LAT_MAX, 28);
        row.lon = rand_angle(LON_MAX, 29);
        row.in_fence = 1'b0;
        send_point(row);
        phase_count++;
      end
      drain();
      stall_pct = 0;
    end

    $display("%0d points sent, %0d results checked over six reference/radius settings",
             words_in, words_out);
    $display("flow control: free run, sender gaps, receiver stalls, both, long hold-off");
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0t %0d results never arrived, %0d mismatches", $time, result_q.size(),
               mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
